[hdl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is low.
`define BLPD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("blpd check failed");

// Next-cycle implication, held off while reset is low.
`define BLPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("blpd check failed");

`endif

[hdl/blpd_pkg.sv]
package blpd_pkg;

	// field widths
	localparam int OP_W    = 2;
	localparam int LVL_W   = 8;
	localparam int IDX_W   = 4;
	localparam int TVAL_W  = 16;
	localparam int SCALE_W = 16;
	localparam int DUTY_W  = 16;
	localparam int NS_W    = 30;
	localparam int PCT_W   = 7;
	localparam int GPIO_W  = 2;
	localparam int CNT_W   = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 30;

	// stream packing
	localparam int IN_TDATA_W  = 32;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 64;
	localparam int O_DUTY = 0;
	localparam int O_NS   = 16;
	localparam int O_UPD  = 46;
	localparam int O_GPIO = 47;
	localparam int O_PCT  = 49;
	localparam int O_ERR  = 56;

	// divider numerators
	localparam int SHORT_W = 23;
	localparam int NUM_W   = 46;

	localparam int DEFAULT_TABLE_DEPTH = 16;

	// request kinds
	localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
	localparam logic [OP_W-1:0] OP_SET  = 2'd1;
	localparam logic [OP_W-1:0] OP_READ = 2'd2;

	// enable pin actions
	localparam logic [GPIO_W-1:0] GPIO_KEEP = 2'd0;
	localparam logic [GPIO_W-1:0] GPIO_OFF  = 2'd1;
	localparam logic [GPIO_W-1:0] GPIO_ON   = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_SCALE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_NS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_COUNT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PWM_PRESENT = 2'd3;

	localparam logic [SCALE_W-1:0] SCALE_DEFAULT = 16'd100;
	localparam logic [PCT_W-1:0]   PCT_FULL      = 7'd100;
	localparam logic [PCT_W-1:0]   ROUND_HALF    = 7'd50;
	localparam logic [PCT_W-1:0]   DELTA_INIT    = 7'd101;

endpackage

[hdl/backlight_level_to_pwm_duty.sv]
// Channel   | Signals                              | Payload (lowest bit first)
// ----------+--------------------------------------+--------------------------------------------
// requests  | s_axis_tvalid/tready/tdata/tuser     | tdata: level, table_index, table_value
//           |                                      | tuser: op
// results   | m_axis_tvalid/tready/tdata           | tdata: duty, duty_ns, pwm_update,
//           |                                      |        gpio_action, current_percent, error
// registers | cfg_we, cfg_index, cfg_data          | scale, period, table count, pwm present
//
// One request at a time. Loads, reads and sets that bypass the PWM go straight to the hand-over.
// A set with n table entries walks them: per entry a table read, a 23-step percent division
// and a compare; then a 46-step on-time division and a 23-step percent division (skipped at
// level 0). Without a table, level*scale/100 is a reciprocal multiply in place of the walk.
// arst_n clears control, registers and the stored percent; the table keeps no reset.
// A held result stalls only the final hand-over; the next request waits until then.
module backlight_level_to_pwm_duty
	import blpd_pkg::*;
#(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// request stream
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // level[7:0], table_index[11:8], table_value[27:12]
	input  logic [IN_TUSER_W-1:0]  s_axis_tuser,  // op[1:0]
	// result stream
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // duty[15:0], duty_ns[45:16], pwm_update[46],
	                                              // gpio_action[48:47], current_percent[55:49],
	                                              // error[56]
	// register writes
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int N_W    = ($clog2(TABLE_DEPTH + 1) > CNT_W) ? $clog2(TABLE_DEPTH + 1) : CNT_W;
	localparam int STEP_W = $clog2(NUM_W + 1);

	// divide by 100 as a multiply by ceil(2^30 / 100), exact for 23-bit numerators
	localparam int            RECIP_W     = 24;
	localparam int            RECIP_SHIFT = 30;
	localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;
	localparam int            LPROD_W     = SHORT_W + RECIP_W;

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD   = 4'd1;  // table address presented
	localparam logic [3:0] S_ENT  = 4'd2;  // entry data back, start its percent
	localparam logic [3:0] S_LVL  = 4'd3;  // no table: latch level*scale + 50
	localparam logic [3:0] S_NS   = 4'd4;  // start period*duty/scale
	localparam logic [3:0] S_PCT  = 4'd5;  // start percent of the chosen duty
	localparam logic [3:0] S_DIV  = 4'd6;  // divider running
	localparam logic [3:0] S_POST = 4'd7;  // take the quotient
	localparam logic [3:0] S_DONE = 4'd8;  // hand the result over

	// what the running division is for
	localparam logic [1:0] DV_ENT = 2'd0;
	localparam logic [1:0] DV_LVL = 2'd1;
	localparam logic [1:0] DV_NS  = 2'd2;
	localparam logic [1:0] DV_PCT = 2'd3;

	// registers
	logic [SCALE_W-1:0] scale_q;
	logic [NS_W-1:0]    period_q;
	logic [CNT_W-1:0]   count_q;
	logic               present_q;

	// control
	logic [3:0]         state_q;
	logic [PCT_W-1:0]   stored_q;
	logic               m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;

	// table memory
	logic [TVAL_W-1:0]  mem [TABLE_DEPTH];
	logic [TVAL_W-1:0]  rd_data_q;

	// datapath
	logic [PCT_W-1:0]   lv_q;
	logic [DUTY_W-1:0]  duty_q;
	logic [NS_W-1:0]    dns_q;
	logic               upd_q;
	logic [GPIO_W-1:0]  gpio_q;
	logic               err_q;
	logic [PCT_W-1:0]   pct_q;
	logic [PCT_W-1:0]   closest_gap_q;
	logic [DUTY_W-1:0]  best_duty_q;
	logic [DUTY_W-1:0]  ent_duty_q;
	logic [ADDR_W-1:0]  scan_idx_q;
	logic [NUM_W-1:0]   num_q;
	logic [SCALE_W-1:0] rem_q;
	logic [SCALE_W-1:0] div_q;
	logic [STEP_W-1:0]  step_q;
	logic [1:0]         dv_q;

	// request fields
	logic [OP_W-1:0]    in_op;
	logic [LVL_W-1:0]   in_level;
	logic [IDX_W-1:0]   in_idx;
	logic [TVAL_W-1:0]  in_val;
	logic [PCT_W-1:0]   in_lv;
	logic               s_accept;

	logic [SCALE_W-1:0] scale_eff;
	logic               pwm_ok;
	logic [N_W-1:0]     n_eff;
	logic               last_ent;
	logic               load_we;

	logic [DUTY_W-1:0]  ent_clamp;
	logic [DUTY_W-1:0]  pct_op;
	logic [SHORT_W-1:0] pct_num;
	logic [SHORT_W-1:0] lvl_num;
	logic [NUM_W-1:0]   ns_num;
	logic [LPROD_W-1:0] lvl_prod;

	logic [SCALE_W:0]   rem_ext;
	logic               rem_ge;
	logic [SCALE_W:0]   rem_sub;

	logic [PCT_W-1:0]   quot_pct;
	logic [PCT_W-1:0]   delta;
	logic               better;
	logic               hand_over;

	assign in_op    = s_axis_tuser[OP_W-1:0];
	assign in_level = s_axis_tdata[LVL_W-1:0];
	assign in_idx   = s_axis_tdata[LVL_W +: IDX_W];
	assign in_val   = s_axis_tdata[LVL_W + IDX_W +: TVAL_W];
	assign in_lv    = (in_level > LVL_W'(PCT_FULL)) ? PCT_FULL : in_level[PCT_W-1:0];

	assign s_axis_tready = (state_q == S_IDLE);
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	// a zero scale counts as 100
	assign scale_eff = (scale_q == '0) ? SCALE_DEFAULT : scale_q;
	assign pwm_ok    = present_q && (period_q != '0);
	assign n_eff     = (N_W'(count_q) > N_W'(TABLE_DEPTH)) ? N_W'(TABLE_DEPTH) : N_W'(count_q);
	assign last_ent  = (N_W'(scan_idx_q) == n_eff - N_W'(1));
	assign load_we   = s_accept && (in_op == OP_LOAD) && (32'(in_idx) < TABLE_DEPTH);

	// numerators: percent of a duty, duty of a level, on-time
	assign ent_clamp = (rd_data_q > scale_eff) ? scale_eff : rd_data_q;
	assign pct_op    = (state_q == S_ENT) ? ent_clamp : duty_q;
	assign pct_num   = SHORT_W'(pct_op) * SHORT_W'(PCT_FULL) + SHORT_W'(scale_eff >> 1);
	assign lvl_num   = SHORT_W'(lv_q) * SHORT_W'(scale_eff) + SHORT_W'(ROUND_HALF);
	assign ns_num    = NUM_W'(period_q) * NUM_W'(duty_q);

	// level*scale + 50 over 100, taken from the latched numerator
	assign lvl_prod  = LPROD_W'(num_q[SHORT_W-1:0]) * LPROD_W'(RECIP_100);

	// one restoring step: shift in the next numerator bit, subtract when it fits
	assign rem_ext = {rem_q, num_q[NUM_W-1]};
	assign rem_ge  = (rem_ext >= {1'b0, div_q});
	assign rem_sub = rem_ext - {1'b0, div_q};

	// nearest-percent search: strict compare keeps the first entry on a tie
	assign quot_pct = num_q[PCT_W-1:0];
	assign delta    = (quot_pct > lv_q) ? (quot_pct - lv_q) : (lv_q - quot_pct);
	assign better   = (delta < closest_gap_q);

	assign hand_over = (state_q == S_DONE) && (!m_valid_q || m_axis_tready);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q   <= SCALE_DEFAULT;
			period_q  <= '0;
			count_q   <= '0;
			present_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DUTY_SCALE:  scale_q   <= cfg_data[SCALE_W-1:0];
				CFG_PERIOD_NS:   period_q  <= cfg_data[NS_W-1:0];
				CFG_TABLE_COUNT: count_q   <= cfg_data[CNT_W-1:0];
				CFG_PWM_PRESENT: present_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// table: write on a load, read the scan address every cycle.
	// Loads and scans belong to different requests, so no access overlaps.
	always_ff @(posedge clk) begin
		if (load_we) begin
			mem[ADDR_W'(in_idx)] <= in_val;
		end
		rd_data_q <= mem[scan_idx_q];
	end

	// sequencer, stored percent and the result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			stored_q  <= '0;
			m_valid_q <= 1'b0;
		end else begin
			// load a new result, or drop the old one once taken
			if (hand_over) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_accept) begin
						if (in_op == OP_SET && pwm_ok) begin
							state_q <= (n_eff != '0) ? S_RD : S_LVL;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_RD:  state_q <= S_ENT;
				S_ENT: state_q <= S_DIV;
				S_LVL: state_q <= S_POST;
				S_NS:  state_q <= S_DIV;
				S_PCT: state_q <= S_DIV;
				S_DIV: begin
					if (step_q == STEP_W'(1)) begin
						state_q <= S_POST;
					end
				end
				S_POST: begin
					case (dv_q)
						DV_ENT:  state_q <= last_ent ? S_NS : S_RD;
						DV_LVL:  state_q <= S_NS;
						DV_NS:   state_q <= (lv_q != '0) ? S_PCT : S_DONE;
						default: state_q <= S_DONE;
					endcase
				end
				S_DONE: begin
					if (hand_over) begin
						stored_q <= pct_q;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_accept) begin
					lv_q          <= in_lv;
					duty_q        <= '0;
					dns_q         <= '0;
					upd_q         <= 1'b0;
					gpio_q        <= GPIO_KEEP;
					err_q         <= 1'b0;
					pct_q         <= stored_q;
					closest_gap_q <= DELTA_INIT;
					scan_idx_q    <= '0;
					if (in_op == OP_SET) begin
						if (pwm_ok) begin
							// percent for a nonzero level is filled in later
							upd_q  <= 1'b1;
							gpio_q <= (in_lv == '0) ? GPIO_OFF : GPIO_KEEP;
							pct_q  <= '0;
						end else begin
							gpio_q <= (in_lv == '0) ? GPIO_OFF : GPIO_ON;
							pct_q  <= (in_lv == '0) ? '0 : PCT_FULL;
							err_q  <= (in_lv != '0) && present_q;
						end
					end
				end
			end
			S_ENT: begin
				ent_duty_q <= ent_clamp;
				num_q      <= {pct_num, (NUM_W - SHORT_W)'(0)};
				rem_q      <= '0;
				div_q      <= scale_eff;
				step_q     <= STEP_W'(SHORT_W);
				dv_q       <= DV_ENT;
			end
			S_LVL: begin
				num_q <= NUM_W'(lvl_num);
				dv_q  <= DV_LVL;
			end
			S_NS: begin
				num_q  <= ns_num;
				rem_q  <= '0;
				div_q  <= scale_eff;
				step_q <= STEP_W'(NUM_W);
				dv_q   <= DV_NS;
			end
			S_PCT: begin
				num_q  <= {pct_num, (NUM_W - SHORT_W)'(0)};
				rem_q  <= '0;
				div_q  <= scale_eff;
				step_q <= STEP_W'(SHORT_W);
				dv_q   <= DV_PCT;
			end
			S_DIV: begin
				rem_q  <= rem_ge ? rem_sub[SCALE_W-1:0] : rem_ext[SCALE_W-1:0];
				num_q  <= {num_q[NUM_W-2:0], rem_ge};
				step_q <= step_q - STEP_W'(1);
			end
			S_POST: begin
				case (dv_q)
					DV_ENT: begin
						if (better) begin
							closest_gap_q <= delta;
							best_duty_q   <= ent_duty_q;
						end
						if (last_ent) begin
							duty_q <= better ? ent_duty_q : best_duty_q;
						end else begin
							scan_idx_q <= scan_idx_q + ADDR_W'(1);
						end
					end
					DV_LVL:  duty_q <= lvl_prod[RECIP_SHIFT +: DUTY_W];
					DV_NS:   dns_q  <= num_q[NS_W-1:0];
					default: pct_q  <= quot_pct;
				endcase
			end
			S_DONE: begin
				if (hand_over) begin
					m_data_q <= {(OUT_TDATA_W - O_ERR - 1)'(0), err_q, pct_q, gpio_q, upd_q,
						dns_q, duty_q};
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

[hdl/blpd_checker.sv]
`include "assert_macros.svh"

module blpd_checker
	import blpd_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// one request in flight: taking one closes the input until its result is out
	`BLPD_ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

	// a held result keeps its payload
	`BLPD_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// an error means the PWM was bypassed: pins on, nothing programmed
	`BLPD_ASSERT_IMP(a_err_shape, clk, arst_n, m_axis_tvalid && m_axis_tdata[O_ERR], (m_axis_tdata[O_GPIO +: GPIO_W] == GPIO_ON) && !m_axis_tdata[O_UPD])

	// the stored percent never passes full scale
	`BLPD_ASSERT_IMP(a_pct_range, clk, arst_n, m_axis_tvalid, m_axis_tdata[O_PCT +: PCT_W] <= PCT_FULL)

endmodule

bind backlight_level_to_pwm_duty blpd_checker u_blpd_checker (.*);

[sim/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import blpd_pkg::*;

	localparam int DEPTH = DEFAULT_TABLE_DEPTH;

	// The spare request code behaves like a read.
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

	localparam logic [NS_W-1:0] PERIOD_MAX = {NS_W{1'b1}};

	// Run control
	localparam int unsigned CYCLE_LIMIT   = 2_000_000;
	localparam int          PHASES        = 10;
	localparam int          PHASE_ITEMS   = 40;
	localparam int unsigned HOLD_AT       = 120;   // results seen before the long hold-off
	localparam int          HOLD_CYCLES   = 1500;  // several full table walks
	localparam int          DRAIN_CYCLES  = 600;   // longer than a 16-entry table walk

	// Table contents loaded before any set can walk the table. The pair 48/52
	// sits either side of 50 percent at a scale of 100, so a set of 50 is a tie.
	localparam logic [TVAL_W-1:0] TABLE_SEED [DEPTH] = '{
		16'd0,  16'hFFFF, 16'd48, 16'd52, 16'd10, 16'd20, 16'd30, 16'd40,
		16'd60, 16'd70,   16'd80, 16'd90, 16'd95, 16'd99, 16'd101, 16'd5
	};

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [LVL_W-1:0]  level;
		logic [IDX_W-1:0]  slot;
		logic [TVAL_W-1:0] entry;
	} request_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic [NS_W-1:0]   on_ns;
		logic              pwm_update;
		logic [GPIO_W-1:0] gpio;
		logic [PCT_W-1:0]  percent;
		logic              fault;
	} duty_result_t;

	// Tracks the mapper's table, stored percent and registers, and holds the
	// results still owed by the block in request order.
	class duty_ledger;
		duty_result_t      pending_q[$];
		logic [TVAL_W-1:0] table_copy [DEPTH];
		logic [PCT_W-1:0]  percent_copy;
		logic [SCALE_W-1:0] scale_r;
		logic [NS_W-1:0]   period_r;
		logic [CNT_W-1:0]  count_r;
		logic              pwm_r;
		int unsigned       mismatches;
		int unsigned       results_seen;

		function new();
			foreach (table_copy[i])
				table_copy[i] = '0;
			percent_copy = '0;
			scale_r      = SCALE_DEFAULT;
			period_r     = '0;
			count_r      = '0;
			pwm_r        = 1'b0;
			mismatches   = 0;
			results_seen = 0;
		endfunction

		function int unsigned full_scale();
			return (scale_r == '0) ? int'(SCALE_DEFAULT) : int'(scale_r);
		endfunction

		function int unsigned percent_of_duty(int unsigned d);
			int unsigned s;
			s = full_scale();
			if (d > s)
				d = s;
			return (d * int'(PCT_FULL) + s / 2) / s;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_DUTY_SCALE:  scale_r  = data[SCALE_W-1:0];
				CFG_PERIOD_NS:   period_r = data[NS_W-1:0];
				CFG_TABLE_COUNT: count_r  = data[CNT_W-1:0];
				CFG_PWM_PRESENT: pwm_r    = data[0];
				default: ;
			endcase
		endfunction

		function duty_result_t predict_duty_result(request_t r);
			duty_result_t res;
			logic [LVL_W-1:0] lv;
			logic pwm_ok;
			int unsigned s, n, i, best, closest_gap, p, delta, chosen;
			logic [63:0] product;
			res = '0;
			s = full_scale();
			case (r.op)
				OP_LOAD: table_copy[r.slot] = r.entry;
				OP_SET: begin
					pwm_ok = pwm_r && (period_r != '0);
					lv = (r.level > LVL_W'(PCT_FULL)) ? LVL_W'(PCT_FULL) : r.level;
					chosen = 0;
					if (pwm_ok) begin
						n = (count_r > DEPTH) ? DEPTH : count_r;
						if (n > 0) begin
							// nearest rounded percent, first entry kept on a tie
							best = 0;
							closest_gap = int'(DELTA_INIT);
							for (i = 0; i < n; i++) begin
								p = percent_of_duty(table_copy[i]);
								delta = (p > lv) ? p - lv : lv - p;
								if (delta < closest_gap) begin
									best = i;
									closest_gap = delta;
								end
							end
							chosen = (table_copy[best] > s) ? s : table_copy[best];
						end else begin
							chosen = (lv * s + int'(ROUND_HALF)) / int'(PCT_FULL);
						end
						product = 64'(period_r) * 64'(chosen);
						res.duty = DUTY_W'(chosen);
						res.on_ns = NS_W'(product / 64'(s));
						res.pwm_update = 1'b1;
					end
					if (lv == '0) begin
						res.gpio = GPIO_OFF;
						percent_copy = '0;
					end else if (pwm_ok) begin
						percent_copy = PCT_W'(percent_of_duty(chosen));
					end else begin
						res.gpio = GPIO_ON;
						percent_copy = PCT_FULL;
						res.fault = pwm_r;
					end
				end
				default: ;  // read and the spare code change nothing
			endcase
			res.percent = percent_copy;
			return res;
		endfunction

		function void note_request(request_t r);
			pending_q.push_back(predict_duty_result(r));
		endfunction

		task report(string what, longint unsigned got, longint unsigned want);
			mismatches++;
			if (mismatches <= 40)
				$display("result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
		endtask

		task check_result(logic [OUT_TDATA_W-1:0] t);
			duty_result_t want;
			results_seen++;
			if (pending_q.size() == 0) begin
				report("result with no request outstanding, tdata", t, 0);
				return;
			end
			want = pending_q.pop_front();
			if (t[O_DUTY +: DUTY_W] !== want.duty)
				report("duty", t[O_DUTY +: DUTY_W], want.duty);
			if (t[O_NS +: NS_W] !== want.on_ns)
				report("duty_ns", t[O_NS +: NS_W], want.on_ns);
			if (t[O_UPD] !== want.pwm_update)
				report("pwm_update", t[O_UPD], want.pwm_update);
			if (t[O_GPIO +: GPIO_W] !== want.gpio)
				report("gpio_action", t[O_GPIO +: GPIO_W], want.gpio);
			if (t[O_PCT +: PCT_W] !== want.percent)
				report("current_percent", t[O_PCT +: PCT_W], want.percent);
			if (t[O_ERR] !== want.fault)
				report("error", t[O_ERR], want.fault);
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic [IN_TUSER_W-1:0]  s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	duty_ledger  ledger = new();
	int unsigned cycle_count = 0;
	int          burst_left = 0;

	backlight_level_to_pwm_duty i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #1 clk = ~clk;

	// Watchdog: end the run if the block stops answering.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, ledger.pending_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic request_t make_request(logic [OP_W-1:0] op, logic [LVL_W-1:0] level,
			logic [IDX_W-1:0] slot, logic [TVAL_W-1:0] entry);
		request_t r;
		r.op    = op;
		r.level = level;
		r.slot  = slot;
		r.entry = entry;
		return r;
	endfunction

	// Offer one request and hold it until the block takes it. Requests go out
	// in bursts; between bursts drop tvalid for a random gap, which may be
	// zero so that some stretches run back to back. tvalid is only lowered at
	// the start of a gap, never in the step that offers the next request.
	task automatic offer(input request_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tdata  <= {{(IN_TDATA_W - LVL_W - IDX_W - TVAL_W){1'b0}}, r.entry, r.slot, r.level};
		s_axis_tuser  <= r.op;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (s_axis_tready !== 1'b1)
			@(posedge clk);
		ledger.note_request(r);
	endtask

	// Drop tvalid and wait until every owed result has been taken, so that the
	// registers can be rewritten with the block idle.
	task automatic wait_until_idle();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (ledger.pending_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all four registers on consecutive edges. The unused upper bits of
	// the narrow registers carry random junk that the block must ignore.
	task automatic program_registers(input logic [SCALE_W-1:0] scale,
			input logic [NS_W-1:0] period, input logic [CNT_W-1:0] count, input logic present);
		logic [CFG_IDX_W-1:0]  idx  [4];
		logic [CFG_DATA_W-1:0] word [4];
		logic [31:0] junk;
		int k;
		idx = '{CFG_DUTY_SCALE, CFG_PERIOD_NS, CFG_TABLE_COUNT, CFG_PWM_PRESENT};
		for (k = 0; k < 4; k++) begin
			junk = $urandom;
			word[k] = junk[CFG_DATA_W-1:0];
		end
		word[0][SCALE_W-1:0] = scale;
		word[1] = period;
		word[2][CNT_W-1:0] = count;
		word[3][0] = present;
		for (k = 0; k < 4; k++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[k];
			cfg_data  <= word[k];
			@(posedge clk);
			ledger.set_register(idx[k], word[k]);
		end
		cfg_we <= 1'b0;
	endtask

	// Result side: check every accepted result, then pick tready for the next
	// edge. tready follows modes of random length (always ready, coin toss,
	// mostly stalled); once, after HOLD_AT results, hold it low for a long
	// stretch so that a finished result backs up and the request side stalls.
	initial begin : result_sink
		int mode;
		int mode_left;
		int hold_left;
		bit held;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		held = 1'b0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
				ledger.check_result(m_axis_tdata);
			if (!held && ledger.results_seen == HOLD_AT) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 2);
					mode_left = $urandom_range(5, 60);
				end
				mode_left--;
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= ($urandom_range(0, 1) == 1);
					default: m_axis_tready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		request_t r;
		int phase;
		int n;
		int k;
		int unsigned span;
		logic [SCALE_W-1:0] scale;
		logic [NS_W-1:0] period;
		logic [CNT_W-1:0] count;
		logic present;

		// Hold every input at a known value through reset.
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= OP_READ;
		cfg_we        <= 1'b0;
		cfg_index     <= CFG_DUTY_SCALE;
		cfg_data      <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset registers: no PWM, so a nonzero set just switches the pins on.
		offer(make_request(OP_READ, 8'hFF, 4'hF, 16'hFFFF));
		offer(make_request(OP_SPARE, 8'd0, 4'd0, 16'd0));
		offer(make_request(OP_SET, 8'd50, 4'd0, 16'd0));

		// Fill the whole table before any set can walk it.
		for (k = 0; k < DEPTH; k++)
			offer(make_request(OP_LOAD, 8'd0, IDX_W'(k), TABLE_SEED[k]));

		// Table walk with an oversized count: the tie at 50, a clamped level,
		// and level zero with the PWM usable.
		wait_until_idle();
		program_registers(16'd100, NS_W'(1000), 5'd31, 1'b1);
		offer(make_request(OP_SET, 8'd50, 4'd0, 16'd0));
		offer(make_request(OP_SET, 8'd255, 4'd0, 16'd0));
		offer(make_request(OP_SET, 8'd0, 4'd0, 16'd0));

		// Zero scale stands for 100; no table, longest period.
		wait_until_idle();
		program_registers(16'd0, PERIOD_MAX, 5'd0, 1'b1);
		offer(make_request(OP_SET, 8'd37, 4'd0, 16'd0));
		offer(make_request(OP_SET, 8'd100, 4'd0, 16'd0));

		// PWM present but period zero: error on a nonzero level, none at zero.
		wait_until_idle();
		program_registers(16'hFFFF, NS_W'(0), 5'd16, 1'b1);
		offer(make_request(OP_SET, 8'd20, 4'd0, 16'd0));
		offer(make_request(OP_SET, 8'd0, 4'd0, 16'd0));

		// Random phases: a fixed set of corner settings first, then random ones.
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin scale = 16'hFFFF; period = PERIOD_MAX; count = 5'd16; present = 1'b1; end
				1: begin scale = 16'd1; period = NS_W'(1); count = 5'd5; present = 1'b1; end
				2: begin scale = 16'd0; period = NS_W'(12345); count = 5'd0; present = 1'b1; end
				3: begin scale = 16'd100; period = NS_W'(0); count = 5'd0; present = 1'b1; end
				4: begin
					scale = 16'd1000;
					period = NS_W'($urandom);
					count = 5'd20;
					present = 1'b1;
				end
				5: begin
					scale = SCALE_W'($urandom);
					period = NS_W'($urandom);
					count = 5'd0;
					present = 1'b0;
				end
				default: begin
					case ($urandom_range(0, 5))
						0: scale = 16'd0;
						1: scale = 16'd100;
						2: scale = 16'd255;
						3: scale = 16'hFFFF;
						default: scale = SCALE_W'($urandom);
					endcase
					case ($urandom_range(0, 4))
						0: period = NS_W'($urandom_range(1, 100));
						1: period = PERIOD_MAX;
						default: period = NS_W'($urandom);
					endcase
					count = CNT_W'($urandom_range(0, 31));
					present = ($urandom_range(0, 9) != 0);
				end
			endcase
			wait_until_idle();
			program_registers(scale, period, count, present);

			// Keep some load values near the current scale so the table walk
			// has real choices to make.
			span = ledger.full_scale();
			span = span + span / 8;
			if (span > 16'hFFFF)
				span = 16'hFFFF;

			for (n = 0; n < PHASE_ITEMS; n++) begin
				k = $urandom_range(0, 99);
				r = make_request(OP_READ, LVL_W'($urandom), IDX_W'($urandom), TVAL_W'($urandom));
				if (k < 15) begin
					r.op = OP_LOAD;
					if ($urandom_range(0, 1) == 1)
						r.entry = TVAL_W'($urandom_range(0, span));
				end else if (k < 75) begin
					r.op = OP_SET;
					case ($urandom_range(0, 5))
						0: r.level = '0;
						1: r.level = LVL_W'(PCT_FULL);
						2: r.level = LVL_W'($urandom_range(101, 255));
						3, 4: r.level = LVL_W'($urandom_range(0, 100));
						default: ;  // keep the full random byte
					endcase
				end else if (k >= 90) begin
					r.op = OP_SPARE;
				end
				offer(r);
			end
		end

		// Drain, then give a stray result time to show up.
		wait_until_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (ledger.mismatches == 0 && ledger.pending_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
